/* rtl/core/whc_pkg.sv */
package whc_pkg;

    // Field widths
    localparam int ACTION_W   = 3;
    localparam int TEMP_W     = 8;
    localparam int BAND_W     = 6;
    localparam int STEP_W     = 5;
    localparam int SETPT_W    = 7;
    localparam int TIMEOUT_W  = 3;
    localparam int MODE_W     = 2;
    localparam int IDLE_W     = 3;
    localparam int SUM_W      = 12;
    localparam int COUNT_W    = 4;
    localparam int AVG_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Averaging window default
    localparam int WINDOW_SAMPLES_DEF = 10;

    // Decoupling queue depth
    localparam int QUEUE_DEPTH = 2;

    // Action codes on the input channel
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_UP     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DOWN   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POWER  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd4;

    // Register reset values
    localparam logic [BAND_W-1:0]    RST_BAND    = 6'd5;
    localparam logic [STEP_W-1:0]    RST_STEP    = 5'd5;
    localparam logic [SETPT_W-1:0]   RST_MAX     = 7'd75;
    localparam logic [SETPT_W-1:0]   RST_MIN     = 7'd35;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT = 3'd5;

    // State reset value and mode thresholds
    localparam logic [SETPT_W-1:0] RST_TARGET = 7'd60;
    localparam logic [MODE_W-1:0]  MODE_TOP   = 2'd3;
    localparam logic [MODE_W-1:0]  MODE_ADJ   = 2'd2;

    // Decoded operation carried to the execute side
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_SAMPLE = 3'd1,
        OP_UP     = 3'd2,
        OP_DOWN   = 3'd3,
        OP_POWER  = 3'd4,
        OP_TICK   = 3'd5
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [TEMP_W-1:0] temperature;
    } item_t;

    typedef struct packed {
        logic [BAND_W-1:0]    band;
        logic [STEP_W-1:0]    step;
        logic [SETPT_W-1:0]   sp_max;
        logic [SETPT_W-1:0]   sp_min;
        logic [TIMEOUT_W-1:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

/* rtl/core/whc_in_if.sv */
interface whc_in_if;
    logic                           valid;
    logic                           ready;
    logic [whc_pkg::ACTION_W-1:0]   action;
    logic [whc_pkg::TEMP_W-1:0]     temperature;

    modport source (output valid, output action, output temperature, input ready);
    modport sink   (input valid, input action, input temperature, output ready);
endinterface

/* rtl/core/whc_out_if.sv */
interface whc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          heater_on;
    logic                          cooler_on;
    logic                          powered;
    logic                          in_set_mode;
    logic [whc_pkg::SETPT_W-1:0]   setpoint;
    logic [whc_pkg::AVG_W-1:0]     average_temp;

    modport source (output valid, output heater_on, output cooler_on, output powered,
                    output in_set_mode, output setpoint, output average_temp,
                    input ready);
    modport sink   (input valid, input heater_on, input cooler_on, input powered,
                    input in_set_mode, input setpoint, input average_temp,
                    output ready);
endinterface

/* rtl/core/whc_front.sv */
module whc_front (
    whc_in_if.sink          cmd,
    input  logic            q_ready,
    output logic            push,
    output whc_pkg::item_t  push_item
);

    // Accept whenever the queue has room
    assign cmd.ready = q_ready;
    assign push      = cmd.valid && q_ready;

    // Decode the action into an operation
    always_comb
    begin
        push_item.temperature = cmd.temperature;
        case (cmd.action)
            whc_pkg::ACT_SAMPLE: push_item.op = whc_pkg::OP_SAMPLE;
            whc_pkg::ACT_UP:     push_item.op = whc_pkg::OP_UP;
            whc_pkg::ACT_DOWN:   push_item.op = whc_pkg::OP_DOWN;
            whc_pkg::ACT_POWER:  push_item.op = whc_pkg::OP_POWER;
            whc_pkg::ACT_TICK:   push_item.op = whc_pkg::OP_TICK;
            default:             push_item.op = whc_pkg::OP_NONE;
        endcase
    end

endmodule

/* rtl/core/whc_queue.sv */
module whc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  whc_pkg::item_t    push_item,
    input  logic              pop,
    output logic              ready,
    output logic              valid,
    output whc_pkg::item_t    head,
    output whc_pkg::q_stat_t  stat
);

    localparam int DEPTH = whc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    whc_pkg::item_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign ready      = !stat.full;
    assign valid      = !stat.empty;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/core/whc_exec.sv */
module whc_exec #(
    parameter int WindowSamples = whc_pkg::WINDOW_SAMPLES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  whc_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  whc_pkg::item_t  item,
    output logic            pop,
    whc_out_if.source       status
);

    // Reciprocal for the window divide, exact for every 12-bit sum
    localparam int RECIP_SHIFT = whc_pkg::SUM_W + 5;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = whc_pkg::SUM_W + RECIP_W;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + WindowSamples - 1) / WindowSamples;
    localparam logic [whc_pkg::COUNT_W:0] WIN = (whc_pkg::COUNT_W + 1)'(WindowSamples);

    logic                            power_reg, power_next;
    logic [whc_pkg::MODE_W-1:0]      mode_reg, mode_next, mode_inc;
    logic [whc_pkg::IDLE_W-1:0]      idle_reg, idle_next, idle_inc;
    logic [whc_pkg::SETPT_W-1:0]     target_reg, target_next, down_val;
    logic [whc_pkg::SUM_W-1:0]       sum_reg, sum_next, sum_add;
    logic [whc_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                            heater_reg, heater_next;
    logic                            cooler_reg, cooler_next;
    logic [whc_pkg::AVG_W-1:0]       avg_reg, avg_next, avg_new;
    logic [whc_pkg::SETPT_W:0]       up_val;
    logic [PROD_W-1:0]               prod;
    logic                            out_valid_reg;

    // Output register frees when empty or taken
    assign pop = q_valid && (!out_valid_reg || status.ready);

    // Running sum and its window average
    assign sum_add  = sum_reg + whc_pkg::SUM_W'(item.temperature);
    assign prod     = PROD_W'(sum_add) * PROD_W'(RECIP);
    assign avg_new  = prod[RECIP_SHIFT +: whc_pkg::AVG_W];

    // Button and tick helpers
    assign mode_inc = (mode_reg == whc_pkg::MODE_TOP) ? mode_reg : mode_reg + 1'b1;
    assign idle_inc = idle_reg + 1'b1;
    assign up_val   = (whc_pkg::SETPT_W + 1)'(target_reg) + (whc_pkg::SETPT_W + 1)'(cfg.step);
    assign down_val = (target_reg >= whc_pkg::SETPT_W'(cfg.step))
                      ? target_reg - whc_pkg::SETPT_W'(cfg.step) : '0;

    // State update for one beat
    always_comb
    begin
        power_next  = power_reg;
        mode_next   = mode_reg;
        idle_next   = idle_reg;
        target_next = target_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        heater_next = heater_reg;
        cooler_next = cooler_reg;
        avg_next    = avg_reg;
        case (item.op)
            whc_pkg::OP_SAMPLE:
            begin
                if (power_reg)
                begin
                    if ({1'b0, count_reg} + 1'b1 >= WIN)
                    begin
                        avg_next   = avg_new;
                        sum_next   = '0;
                        count_next = '0;
                        if (9'(avg_new) + 9'(cfg.band) <= 9'(target_reg))
                        begin
                            heater_next = 1'b1;
                            cooler_next = 1'b0;
                        end
                        if (9'(avg_new) >= 9'(target_reg) + 9'(cfg.band))
                        begin
                            heater_next = 1'b0;
                            cooler_next = 1'b1;
                        end
                    end
                    else
                    begin
                        sum_next   = sum_add;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            whc_pkg::OP_UP:
            begin
                idle_next = '0;
                mode_next = mode_inc;
                if (mode_inc >= whc_pkg::MODE_ADJ && target_reg < cfg.sp_max)
                begin
                    target_next = (up_val > (whc_pkg::SETPT_W + 1)'(cfg.sp_max))
                                  ? cfg.sp_max : up_val[whc_pkg::SETPT_W-1:0];
                end
            end
            whc_pkg::OP_DOWN:
            begin
                idle_next = '0;
                mode_next = mode_inc;
                if (mode_inc >= whc_pkg::MODE_ADJ && target_reg > cfg.sp_min)
                begin
                    target_next = (down_val < cfg.sp_min) ? cfg.sp_min : down_val;
                end
            end
            whc_pkg::OP_POWER:
            begin
                power_next = !power_reg;
                if (power_reg)
                begin
                    heater_next = 1'b0;
                    cooler_next = 1'b0;
                    mode_next   = '0;
                    idle_next   = '0;
                end
            end
            whc_pkg::OP_TICK:
            begin
                if (mode_reg != '0)
                begin
                    if (idle_inc == cfg.timeout)
                    begin
                        mode_next = '0;
                        idle_next = '0;
                    end
                    else
                    begin
                        idle_next = idle_inc;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg     <= 1'b0;
            mode_reg      <= '0;
            idle_reg      <= '0;
            target_reg    <= whc_pkg::RST_TARGET;
            sum_reg       <= '0;
            count_reg     <= '0;
            heater_reg    <= 1'b0;
            cooler_reg    <= 1'b0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                power_reg  <= power_next;
                mode_reg   <= mode_next;
                idle_reg   <= idle_next;
                target_reg <= target_next;
                sum_reg    <= sum_next;
                count_reg  <= count_next;
                heater_reg <= heater_next;
                cooler_reg <= cooler_next;
                avg_reg    <= avg_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status.heater_on    <= heater_next;
            status.cooler_on    <= cooler_next;
            status.powered      <= power_next;
            status.in_set_mode  <= (mode_next != '0);
            status.setpoint     <= target_next;
            status.average_temp <= avg_next;
        end
    end

    assign status.valid = out_valid_reg;

endmodule

/* rtl/core/water_heater_thermostat_core.sv */
// Flow: a beat accepted on cmd enters the queue at the accepting edge and is written to the result
// register when the execute stage pops it, which waits while a result is held on status.
// Throughput: one beat per cycle while status takes each result; the execute stage registers all state on a pop.
// The two-entry queue lets cmd keep accepting while a result waits on status.
// Reset: rst_n is asynchronous, active low; it empties the queue, clears the result valid,
// loads the registers and state with their defaults (setpoint 60, power off).
module water_heater_thermostat_core #(
    parameter int WindowSamples = whc_pkg::WINDOW_SAMPLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    whc_in_if.sink                            cmd,
    whc_out_if.source                         status,
    input  logic                              cfg_wr_en,
    input  logic [whc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [whc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    whc_pkg::cfg_t      cfg_reg;
    whc_pkg::item_t     push_item, head;
    whc_pkg::q_stat_t   q_stat;
    logic               push, pop, q_ready, q_valid;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band    <= whc_pkg::RST_BAND;
            cfg_reg.step    <= whc_pkg::RST_STEP;
            cfg_reg.sp_max  <= whc_pkg::RST_MAX;
            cfg_reg.sp_min  <= whc_pkg::RST_MIN;
            cfg_reg.timeout <= whc_pkg::RST_TIMEOUT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                whc_pkg::CFG_BAND:    cfg_reg.band    <= cfg_data[whc_pkg::BAND_W-1:0];
                whc_pkg::CFG_STEP:    cfg_reg.step    <= cfg_data[whc_pkg::STEP_W-1:0];
                whc_pkg::CFG_MAX:     cfg_reg.sp_max  <= cfg_data[whc_pkg::SETPT_W-1:0];
                whc_pkg::CFG_MIN:     cfg_reg.sp_min  <= cfg_data[whc_pkg::SETPT_W-1:0];
                whc_pkg::CFG_TIMEOUT: cfg_reg.timeout <= cfg_data[whc_pkg::TIMEOUT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front: accept and decode
    whc_front u_front (
        .cmd       (cmd),
        .q_ready   (q_ready),
        .push      (push),
        .push_item (push_item)
    );

    // Decoupling queue
    whc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .ready     (q_ready),
        .valid     (q_valid),
        .head      (head),
        .stat      (q_stat)
    );

    // Back: state update and result register
    whc_exec #(
        .WindowSamples (WindowSamples)
    ) u_exec (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .item    (head),
        .pop     (pop),
        .status  (status)
    );

    // Queue never reports full and empty together
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // Heater and cooler are never driven together
    a_elements_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid |-> !(status.heater_on && status.cooler_on))
        else $error("heater and cooler both on");

    // With power off both elements are off
    a_unpowered_off: assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && !status.powered) |-> (!status.heater_on && !status.cooler_on))
        else $error("element on while unpowered");

    // A popped beat always lands in the result register
    a_pop_lands: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> status.valid)
        else $error("result lost after pop");

endmodule
